/* hdl/sfsa_pkg.sv */
package sfsa_pkg;

    localparam int ADDR_W = 48;
    localparam int LEN_W  = 49;
    localparam int SLAB_W = 33;

    localparam logic [1:0] ACT_ALLOC   = 2'd0;
    localparam logic [1:0] ACT_FREE    = 2'd1;
    localparam logic [1:0] ACT_RESERVE = 2'd2;

    localparam logic [2:0] STS_OK         = 3'd0;
    localparam logic [2:0] STS_NO_SPACE   = 3'd1;
    localparam logic [2:0] STS_NOT_FREE   = 3'd2;
    localparam logic [2:0] STS_TABLE_FULL = 3'd3;
    localparam logic [2:0] STS_OVERLAP    = 3'd4;

    localparam logic [1:0] CFG_REGION_START = 2'd0;
    localparam logic [1:0] CFG_REGION_SIZE  = 2'd1;
    localparam logic [1:0] CFG_SLAB_SIZE    = 2'd2;

    localparam logic [SLAB_W-1:0] SLAB_RESET = 33'd4096;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_DECIDE,
        ST_UPDATE
    } state_t;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_SHRINK_FIRST,
        CMD_DROP_FIRST,
        CMD_SHRINK_HOLD,
        CMD_DROP_HOLD,
        CMD_TRIM_HOLD,
        CMD_SPLIT,
        CMD_GROW_PREV,
        CMD_MERGE_BOTH,
        CMD_MERGE_NEXT,
        CMD_INSERT
    } cmd_t;

    typedef struct packed {
        logic accept;
        logic commit;
        cmd_t cmd;
    } dp_cmd_t;

    typedef struct packed {
        logic busy_rebuild;
        logic any_fit;
        logic first_exact;
        logic any_hold;
        logic hold_head;
        logic hold_tail;
        logic prev_over;
        logic prev_meet;
        logic next_over;
        logic next_meet;
        logic end_over;
        logic full;
    } dp_status_t;

endpackage

/* hdl/sfsa_dp.sv */
module sfsa_dp #(
    parameter int MAX_SEGMENTS = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    input  logic [1:0]                    cfg_index,
    input  logic [sfsa_pkg::LEN_W-1:0]    cfg_data,
    input  logic [sfsa_pkg::ADDR_W-1:0]   in_offset,
    input  sfsa_pkg::dp_cmd_t             ctl,
    output sfsa_pkg::dp_status_t          sts,
    output logic [sfsa_pkg::ADDR_W-1:0]   granted
);

    localparam int N     = MAX_SEGMENTS;
    localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
    localparam int AW    = sfsa_pkg::ADDR_W;
    localparam int LW    = sfsa_pkg::LEN_W;
    localparam int SW    = sfsa_pkg::SLAB_W;

    logic [AW-1:0]    region_start_reg;
    logic [LW-1:0]    region_size_reg;
    logic [SW-1:0]    slab_size_reg;
    logic             rebuild_reg;
    logic [CNT_W-1:0] count_reg, count_next;

    logic [AW-1:0] st_reg [N];
    logic [LW-1:0] ln_reg [N];
    logic [AW-1:0] st_next [N];
    logic [LW-1:0] ln_next [N];
    logic [LW-1:0] cend [N];

    logic [AW-1:0] off_reg;
    logic [LW-1:0] end_reg;
    logic [AW-1:0] granted_reg, granted_next;

    // per-cell compare flags, refreshed every cycle
    logic [N-1:0] v_reg, fit_reg, ex_reg, lt_reg, hold_reg, head_reg, tail_reg;
    logic [N-1:0] pover_reg, pmeet_reg, nover_reg, nmeet_reg;
    logic [N-1:0] v_next, fit_next, ex_next, lt_next, hold_next, head_next, tail_next;
    logic [N-1:0] pover_next, pmeet_next, nover_next, nmeet_next;

    logic [N-1:0] first, ge_first, ge_hold, prev, pos, nxt, ge_nxt, ge_pos;
    logic [N-1:0] split_up, split_ld;

    logic [SW-1:0] sl;
    logic [LW-1:0] sl_w;
    logic [LW-1:0] room, clip_len;

    assign sl   = (slab_size_reg == '0) ? SW'(1) : slab_size_reg;
    assign sl_w = LW'(sl);
    assign room = {1'b1, {AW{1'b0}}} - {1'b0, region_start_reg};
    assign clip_len = (region_size_reg > room) ? room : region_size_reg;

    // configuration registers; a write to a known register schedules a rebuild
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_start_reg <= '0;
            region_size_reg  <= '0;
            slab_size_reg    <= sfsa_pkg::SLAB_RESET;
            rebuild_reg      <= 1'b0;
            count_reg        <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    sfsa_pkg::CFG_REGION_START:
                    begin
                        region_start_reg <= cfg_data[AW-1:0];
                        rebuild_reg      <= 1'b1;
                    end
                    sfsa_pkg::CFG_REGION_SIZE:
                    begin
                        region_size_reg <= cfg_data;
                        rebuild_reg     <= 1'b1;
                    end
                    sfsa_pkg::CFG_SLAB_SIZE:
                    begin
                        slab_size_reg <= cfg_data[SW-1:0];
                        rebuild_reg   <= 1'b1;
                    end
                    default:
                    begin
                        rebuild_reg <= 1'b0;
                    end
                endcase
            end
            else
            begin
                rebuild_reg <= 1'b0;
            end
            count_reg <= count_next;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (rebuild_reg)
        begin
            count_next = (clip_len < sl_w) ? CNT_W'(0) : CNT_W'(1);
        end
        else if (ctl.commit)
        begin
            case (ctl.cmd)
                sfsa_pkg::CMD_SPLIT,
                sfsa_pkg::CMD_INSERT:     count_next = count_reg + CNT_W'(1);
                sfsa_pkg::CMD_DROP_FIRST,
                sfsa_pkg::CMD_DROP_HOLD,
                sfsa_pkg::CMD_MERGE_BOTH: count_next = count_reg - CNT_W'(1);
                default:                  count_next = count_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.accept)
        begin
            off_reg <= in_offset;
            end_reg <= {1'b0, in_offset} + sl_w;
        end
        if (ctl.commit)
        begin
            granted_reg <= granted_next;
        end
        v_reg     <= v_next;
        fit_reg   <= fit_next;
        ex_reg    <= ex_next;
        lt_reg    <= lt_next;
        hold_reg  <= hold_next;
        head_reg  <= head_next;
        tail_reg  <= tail_next;
        pover_reg <= pover_next;
        pmeet_reg <= pmeet_next;
        nover_reg <= nover_next;
        nmeet_reg <= nmeet_next;
    end

    // selection masks from the registered flags
    assign first    = fit_reg & (~fit_reg + N'(1));
    assign ge_first = ~(first - N'(1));
    assign ge_hold  = ~(hold_reg - N'(1));
    assign prev     = lt_reg & ~(lt_reg >> 1);
    assign pos      = ~lt_reg & ((lt_reg << 1) | N'(1));
    assign nxt      = pos & v_reg;
    assign ge_nxt   = ~(nxt - N'(1));
    assign ge_pos   = ~(pos - N'(1));
    assign split_ld = hold_reg << 1;
    assign split_up = ge_hold & ~hold_reg & ~split_ld;

    assign sts.busy_rebuild = rebuild_reg;
    assign sts.any_fit      = |fit_reg;
    assign sts.first_exact  = |(first & ex_reg);
    assign sts.any_hold     = |hold_reg;
    assign sts.hold_head    = |(hold_reg & head_reg);
    assign sts.hold_tail    = |(hold_reg & tail_reg);
    assign sts.prev_over    = |(prev & pover_reg);
    assign sts.prev_meet    = |(prev & pmeet_reg);
    assign sts.next_over    = |(nxt & nover_reg);
    assign sts.next_meet    = |(nxt & nmeet_reg);
    assign sts.end_over     = end_reg[AW] && (end_reg[AW-1:0] != '0);
    assign sts.full         = (count_reg == CNT_W'(MAX_SEGMENTS));

    always_comb
    begin
        granted_next = '0;
        if (ctl.cmd == sfsa_pkg::CMD_SHRINK_FIRST || ctl.cmd == sfsa_pkg::CMD_DROP_FIRST)
        begin
            for (int i = 0; i < N; i++)
            begin
                granted_next = granted_next | ({AW{first[i]}} & st_reg[i]);
            end
        end
    end

    assign granted = granted_reg;

    for (genvar i = 0; i < N; i++)
    begin : g_cell
        localparam int LO = (i == 0) ? 0 : i - 1;
        localparam int HI = (i == N - 1) ? N - 1 : i + 1;

        assign cend[i] = {1'b0, st_reg[i]} + ln_reg[i];

        always_comb
        begin
            v_next[i]     = CNT_W'(i) < count_reg;
            fit_next[i]   = v_next[i] && (ln_reg[i] >= sl_w);
            ex_next[i]    = ln_reg[i] == sl_w;
            lt_next[i]    = v_next[i] && (st_reg[i] < off_reg);
            hold_next[i]  = v_next[i] && (st_reg[i] <= off_reg) && (cend[i] >= end_reg);
            head_next[i]  = st_reg[i] == off_reg;
            tail_next[i]  = cend[i] == end_reg;
            pover_next[i] = cend[i] > {1'b0, off_reg};
            pmeet_next[i] = cend[i] == {1'b0, off_reg};
            nover_next[i] = end_reg > {1'b0, st_reg[i]};
            nmeet_next[i] = end_reg == {1'b0, st_reg[i]};
        end

        always_comb
        begin
            st_next[i] = st_reg[i];
            ln_next[i] = ln_reg[i];
            case (ctl.cmd)
                sfsa_pkg::CMD_SHRINK_FIRST:
                begin
                    if (first[i])
                    begin
                        st_next[i] = st_reg[i] + AW'(sl);
                        ln_next[i] = ln_reg[i] - sl_w;
                    end
                end
                sfsa_pkg::CMD_DROP_FIRST:
                begin
                    if (ge_first[i])
                    begin
                        st_next[i] = st_reg[HI];
                        ln_next[i] = ln_reg[HI];
                    end
                end
                sfsa_pkg::CMD_SHRINK_HOLD:
                begin
                    if (hold_reg[i])
                    begin
                        st_next[i] = st_reg[i] + AW'(sl);
                        ln_next[i] = ln_reg[i] - sl_w;
                    end
                end
                sfsa_pkg::CMD_DROP_HOLD:
                begin
                    if (ge_hold[i])
                    begin
                        st_next[i] = st_reg[HI];
                        ln_next[i] = ln_reg[HI];
                    end
                end
                sfsa_pkg::CMD_TRIM_HOLD:
                begin
                    if (hold_reg[i])
                    begin
                        ln_next[i] = ln_reg[i] - sl_w;
                    end
                end
                sfsa_pkg::CMD_SPLIT:
                begin
                    if (hold_reg[i])
                    begin
                        ln_next[i] = {1'b0, off_reg} - {1'b0, st_reg[i]};
                    end
                    else if (split_ld[i])
                    begin
                        st_next[i] = end_reg[AW-1:0];
                        ln_next[i] = cend[LO] - end_reg;
                    end
                    else if (split_up[i])
                    begin
                        st_next[i] = st_reg[LO];
                        ln_next[i] = ln_reg[LO];
                    end
                end
                sfsa_pkg::CMD_GROW_PREV:
                begin
                    if (prev[i])
                    begin
                        ln_next[i] = ln_reg[i] + sl_w;
                    end
                end
                sfsa_pkg::CMD_MERGE_BOTH:
                begin
                    if (prev[i])
                    begin
                        ln_next[i] = ln_reg[i] + sl_w + ln_reg[HI];
                    end
                    else if (ge_nxt[i])
                    begin
                        st_next[i] = st_reg[HI];
                        ln_next[i] = ln_reg[HI];
                    end
                end
                sfsa_pkg::CMD_MERGE_NEXT:
                begin
                    if (nxt[i])
                    begin
                        st_next[i] = off_reg;
                        ln_next[i] = ln_reg[i] + sl_w;
                    end
                end
                sfsa_pkg::CMD_INSERT:
                begin
                    if (pos[i])
                    begin
                        st_next[i] = off_reg;
                        ln_next[i] = sl_w;
                    end
                    else if (ge_pos[i])
                    begin
                        st_next[i] = st_reg[LO];
                        ln_next[i] = ln_reg[LO];
                    end
                end
                default:
                begin
                    st_next[i] = st_reg[i];
                    ln_next[i] = ln_reg[i];
                end
            endcase
            if (rebuild_reg && i == 0)
            begin
                st_next[i] = region_start_reg;
                ln_next[i] = clip_len;
            end
        end

        always_ff @(posedge clk)
        begin
            if (ctl.commit || rebuild_reg)
            begin
                st_reg[i] <= st_next[i];
                ln_reg[i] <= ln_next[i];
            end
        end
    end

endmodule

/* hdl/sfsa_ctrl.sv */
module sfsa_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           in_action,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [2:0]           out_status,
    output sfsa_pkg::dp_cmd_t    ctl,
    input  sfsa_pkg::dp_status_t sts
);

    sfsa_pkg::state_t state_reg, state_next;
    sfsa_pkg::cmd_t   cmd_reg, cmd_next;
    logic [1:0]       action_reg;
    logic [2:0]       res_reg, res_next;
    logic             out_valid_reg, out_valid_next;
    logic [2:0]       out_status_reg;
    logic             accept, commit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sfsa_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            cmd_reg       <= sfsa_pkg::CMD_NONE;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            cmd_reg       <= cmd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            action_reg <= in_action;
        end
        res_reg <= res_next;
        if (commit)
        begin
            out_status_reg <= res_reg;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        res_next       = res_reg;
        in_ready       = 1'b0;
        accept         = 1'b0;
        commit         = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            sfsa_pkg::ST_IDLE:
            begin
                in_ready = !sts.busy_rebuild;
                accept   = in_valid && !sts.busy_rebuild;
                if (accept)
                begin
                    state_next = sfsa_pkg::ST_CMP;
                end
            end
            sfsa_pkg::ST_CMP:
            begin
                state_next = sfsa_pkg::ST_DECIDE;
            end
            sfsa_pkg::ST_DECIDE:
            begin
                state_next = sfsa_pkg::ST_UPDATE;
                cmd_next   = sfsa_pkg::CMD_NONE;
                res_next   = sfsa_pkg::STS_OK;
                case (action_reg)
                    sfsa_pkg::ACT_ALLOC:
                    begin
                        if (!sts.any_fit)
                            res_next = sfsa_pkg::STS_NO_SPACE;
                        else if (sts.first_exact)
                            cmd_next = sfsa_pkg::CMD_DROP_FIRST;
                        else
                            cmd_next = sfsa_pkg::CMD_SHRINK_FIRST;
                    end
                    sfsa_pkg::ACT_FREE:
                    begin
                        if (sts.end_over || sts.next_over || sts.prev_over)
                            res_next = sfsa_pkg::STS_OVERLAP;
                        else if (sts.prev_meet && sts.next_meet)
                            cmd_next = sfsa_pkg::CMD_MERGE_BOTH;
                        else if (sts.prev_meet)
                            cmd_next = sfsa_pkg::CMD_GROW_PREV;
                        else if (sts.next_meet)
                            cmd_next = sfsa_pkg::CMD_MERGE_NEXT;
                        else if (sts.full)
                            res_next = sfsa_pkg::STS_TABLE_FULL;
                        else
                            cmd_next = sfsa_pkg::CMD_INSERT;
                    end
                    sfsa_pkg::ACT_RESERVE:
                    begin
                        if (!sts.any_hold)
                            res_next = sfsa_pkg::STS_NOT_FREE;
                        else if (sts.hold_head && sts.hold_tail)
                            cmd_next = sfsa_pkg::CMD_DROP_HOLD;
                        else if (sts.hold_head)
                            cmd_next = sfsa_pkg::CMD_SHRINK_HOLD;
                        else if (sts.hold_tail)
                            cmd_next = sfsa_pkg::CMD_TRIM_HOLD;
                        else if (sts.full)
                            res_next = sfsa_pkg::STS_TABLE_FULL;
                        else
                            cmd_next = sfsa_pkg::CMD_SPLIT;
                    end
                    default:
                    begin
                        res_next = sfsa_pkg::STS_NO_SPACE;
                    end
                endcase
            end
            sfsa_pkg::ST_UPDATE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    commit         = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = sfsa_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sfsa_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign ctl.accept = accept;
    assign ctl.commit = commit;
    assign ctl.cmd    = cmd_reg;

endmodule

/* hdl/slab_free_segment_allocator_top.sv */
// Slab allocator over a table of free segments (start, length), kept sorted
// by start, first fit on allocate, coalescing on free.
// Input channel s_axis: tuser = action (alloc, free, reserve), tdata = slab
// offset. Output channel m_axis: tuser = status, tdata = granted offset,
// exactly one word per input word, in order.
// Config channel cfg_*: index 0 region start, 1 region size, 2 slab size;
// always ready. Any known write rebuilds the table in the next cycle, during
// which s_axis_tready is low. Write config only while the block is idle.
// Each request passes through the states CMP, the parallel compare across
// every table cell; DECIDE, the decision; and UPDATE, which shifts/updates
// the cells and loads the output register; it then returns to IDLE, the
// idle state in which the next word is taken from s_axis.
// One request is in flight at a time; the next is taken as soon as the
// previous result sits in the output register, even if not yet taken.
// If m_axis stalls, the finished word waits in the output register and the
// next request holds in its update step until that register frees.
// Reset empties the table, clears region regs, slab size back to 4096.
module slab_free_segment_allocator_top #(
    parameter int MAX_SEGMENTS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // [47:0] slab_offset
    input  logic [1:0]  s_axis_tuser,   // [1:0] action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [47:0] granted_offset
    output logic [2:0]  m_axis_tuser,   // [2:0] status
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [48:0] cfg_data
);

    sfsa_pkg::dp_cmd_t    ctl;
    sfsa_pkg::dp_status_t sts;

    assign cfg_ready = 1'b1;

    sfsa_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_action  (s_axis_tuser),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_status (m_axis_tuser),
        .ctl        (ctl),
        .sts        (sts)
    );

    sfsa_dp #(
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_offset (s_axis_tdata),
        .ctl       (ctl),
        .sts       (sts),
        .granted   (m_axis_tdata)
    );

endmodule

/* hdl/sfsa_checker.sv */
module sfsa_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser,
    input logic        cfg_valid,
    input logic        cfg_ready,
    input logic [1:0]  cfg_index
);

    // a result word waiting on the receiver stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result word dropped while stalled");

    // only a successful allocate carries an offset
    a_grant_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser != sfsa_pkg::STS_OK |-> m_axis_tdata == '0)
        else $error("offset on a failed request");

    a_status_rng: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tuser <= sfsa_pkg::STS_OVERLAP)
        else $error("unknown status code");

    // one request in flight
    a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second request taken while busy");

    // table rebuild blocks input in the cycle after a known register write
    a_rebuild_gap: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready && (cfg_index == sfsa_pkg::CFG_REGION_START
            || cfg_index == sfsa_pkg::CFG_REGION_SIZE
            || cfg_index == sfsa_pkg::CFG_SLAB_SIZE) |=> !s_axis_tready)
        else $error("input taken during table rebuild");

endmodule

bind slab_free_segment_allocator_top sfsa_checker u_sfsa_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index)
);

/* tb/slab_free_segment_allocator_top_test.sv */
module slab_free_segment_allocator_top_test;

    localparam int        SEGS      = 64;
    localparam bit [63:0] ADDR_TOP  = 64'h1_0000_0000_0000;   // 2^48
    localparam bit [63:0] MASK48    = ADDR_TOP - 1;
    localparam logic [1:0] ACT_BAD  = 2'd3;                   // no such action

    // one request word: action travels in tuser, offset in tdata
    typedef struct packed {
        logic [1:0]  act;
        logic [47:0] off;
    } req_t;

    // one response word: status in tuser, granted offset in tdata
    typedef struct packed {
        logic [2:0]  sts;
        logic [47:0] grant;
    } resp_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [48:0] cfg_data = '0;

    slab_free_segment_allocator_top #(.MAX_SEGMENTS(SEGS)) dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // ---------------------------------------------------------------
    // Shadow allocator: own copy of registers and free-segment table
    // ---------------------------------------------------------------
    bit [63:0] sh_rstart = 0;
    bit [63:0] sh_rsize  = 0;
    bit [63:0] sh_slab   = 64'd4096;
    bit [63:0] seg_s [SEGS];
    bit [63:0] seg_l [SEGS];
    int        seg_n = 0;

    req_t  pending_words [$];     // requests still to be offered
    resp_t due_responses [$];     // predicted responses, oldest first

    int errors = 0;
    int words_in = 0;
    int words_out = 0;
    int cfg_writes = 0;
    int sts_seen [8];
    int src_idle = 37;            // percent of cycles the sender holds off
    int snk_idle = 67;            // percent of cycles the receiver stalls

    function automatic bit [63:0] unit_size();
        return (sh_slab == 0) ? 64'd1 : sh_slab;
    endfunction

    function automatic void rebuild();
        bit [63:0] len;
        len = sh_rsize;
        if (len > ADDR_TOP - sh_rstart)
            len = ADDR_TOP - sh_rstart;      // clip at top of address space
        if (len < unit_size())
            seg_n = 0;
        else
        begin
            seg_s[0] = sh_rstart;
            seg_l[0] = len;
            seg_n = 1;
        end
    endfunction

    function automatic void drop_seg(int i);
        for (int j = i; j < seg_n - 1; j++)
        begin
            seg_s[j] = seg_s[j+1];
            seg_l[j] = seg_l[j+1];
        end
        seg_n--;
    endfunction

    function automatic void add_seg(int i, bit [63:0] s, bit [63:0] l);
        for (int j = seg_n; j > i; j--)
        begin
            seg_s[j] = seg_s[j-1];
            seg_l[j] = seg_l[j-1];
        end
        seg_s[i] = s;
        seg_l[i] = l;
        seg_n++;
    endfunction

    function automatic logic [2:0] take_first_fit(output bit [63:0] g);
        bit [63:0] u;
        u = unit_size();
        g = 0;
        for (int i = 0; i < seg_n; i++)
            if (seg_l[i] >= u)
            begin
                g = seg_s[i];
                if (seg_l[i] == u)
                    drop_seg(i);
                else
                begin
                    seg_s[i] += u;
                    seg_l[i] -= u;
                end
                return sfsa_pkg::STS_OK;
            end
        return sfsa_pkg::STS_NO_SPACE;
    endfunction

    function automatic logic [2:0] give_back(bit [63:0] off);
        bit [63:0] u, e;
        int  n;
        bit  hp, hn, mp, mn;
        u = unit_size();
        e = off + u;
        n = 0;
        if (e > ADDR_TOP)
            return sfsa_pkg::STS_OVERLAP;
        while (n < seg_n && seg_s[n] < off)
            n++;
        hp = n > 0;
        hn = n < seg_n;
        if (hn && e > seg_s[n])
            return sfsa_pkg::STS_OVERLAP;
        if (hp && seg_s[n-1] + seg_l[n-1] > off)
            return sfsa_pkg::STS_OVERLAP;
        mp = hp && (seg_s[n-1] + seg_l[n-1] == off);
        mn = hn && (e == seg_s[n]);
        if (mp && mn)
        begin
            seg_l[n-1] += u + seg_l[n];
            drop_seg(n);
        end
        else if (mp)
            seg_l[n-1] += u;
        else if (mn)
        begin
            seg_s[n] = off;
            seg_l[n] += u;
        end
        else
        begin
            if (seg_n >= SEGS)
                return sfsa_pkg::STS_TABLE_FULL;
            add_seg(n, off, u);
        end
        return sfsa_pkg::STS_OK;
    endfunction

    function automatic logic [2:0] claim_at(bit [63:0] off);
        bit [63:0] u, e, s, ce;
        u = unit_size();
        e = off + u;
        for (int i = 0; i < seg_n; i++)
        begin
            s  = seg_s[i];
            ce = s + seg_l[i];
            if (s <= off && ce >= e)
            begin
                if (s == off && ce == e)
                    drop_seg(i);
                else if (s == off)
                begin
                    seg_s[i] += u;
                    seg_l[i] -= u;
                end
                else if (ce == e)
                    seg_l[i] -= u;
                else
                begin
                    if (seg_n >= SEGS)
                        return sfsa_pkg::STS_TABLE_FULL;
                    seg_l[i] = off - s;
                    add_seg(i + 1, e, ce - e);
                end
                return sfsa_pkg::STS_OK;
            end
        end
        return sfsa_pkg::STS_NOT_FREE;
    endfunction

    function automatic resp_t predict_response(req_t r);
        resp_t     o;
        bit [63:0] g;
        g = 0;
        case (r.act)
            sfsa_pkg::ACT_ALLOC:   o.sts = take_first_fit(g);
            sfsa_pkg::ACT_FREE:    o.sts = give_back({16'd0, r.off});
            sfsa_pkg::ACT_RESERVE: o.sts = claim_at({16'd0, r.off});
            default:               o.sts = sfsa_pkg::STS_NO_SPACE;   // action three
        endcase
        o.grant = (o.sts == sfsa_pkg::STS_OK) ? g[47:0] : '0;
        return o;
    endfunction

    task automatic report_mismatch(string what, logic [47:0] want, logic [47:0] got);
        $display("[%0t] mismatch on %s: wanted %h, got %h", $realtime, what, want, got);
        errors++;
    endtask

    // ---------------------------------------------------------------
    // Clock and watchdog
    // ---------------------------------------------------------------
    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("timeout: %0d words still due", due_responses.size());
        $display("slab_free_segment_allocator_top_test: FAIL");
        $finish;
    end

    // ---------------------------------------------------------------
    // Request driver: offers the head of pending_words, idling at random.
    // A held word stays put until taken; prediction happens on acceptance.
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else if (!(s_axis_tvalid && !s_axis_tready))
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                due_responses.push_back(predict_response(pending_words[0]));
                void'(pending_words.pop_front());
                words_in++;
            end
            if (pending_words.size() > 0 && $urandom_range(99) >= src_idle)
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tuser  <= pending_words[0].act;
                s_axis_tdata  <= pending_words[0].off;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // Receiver back-pressure
    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(99) >= snk_idle);
    end

    // ---------------------------------------------------------------
    // Response monitor: each taken word against the oldest prediction
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        resp_t w;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            words_out++;
            if (due_responses.size() == 0)
                report_mismatch("unexpected word", '0, m_axis_tdata);
            else
            begin
                w = due_responses.pop_front();
                sts_seen[w.sts]++;
                if (m_axis_tuser !== w.sts)
                    report_mismatch("status", {45'd0, w.sts}, {45'd0, m_axis_tuser});
                if (m_axis_tdata !== w.grant)
                    report_mismatch("granted offset", w.grant, m_axis_tdata);
            end
        end
    end

    // Register writes land in the shadow copy at the handshake edge
    always @(posedge clk)
    begin
        if (rst_n && cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                sfsa_pkg::CFG_REGION_START:
                begin
                    sh_rstart = {16'd0, cfg_data[47:0]};
                    rebuild();
                end
                sfsa_pkg::CFG_REGION_SIZE:
                begin
                    sh_rsize = {15'd0, cfg_data};
                    rebuild();
                end
                sfsa_pkg::CFG_SLAB_SIZE:
                begin
                    sh_slab = {31'd0, cfg_data[32:0]};
                    rebuild();
                end
                default:
                begin
                    // unknown register: nothing changes
                end
            endcase
            cfg_writes++;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    task automatic write_reg(logic [1:0] idx, logic [48:0] val);
        int seen;
        @(posedge clk);
        seen = cfg_writes;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        wait (cfg_writes != seen);
        cfg_valid <= 1'b0;
    endtask

    task automatic setup(logic [48:0] start, logic [48:0] size, logic [48:0] slab);
        write_reg(sfsa_pkg::CFG_SLAB_SIZE, slab);
        write_reg(sfsa_pkg::CFG_REGION_START, start);
        write_reg(sfsa_pkg::CFG_REGION_SIZE, size);
    endtask

    task automatic push(logic [1:0] a, bit [63:0] o);
        req_t r;
        r.act = a;
        r.off = o[47:0];
        pending_words.push_back(r);
    endtask

    // block only goes idle once every word is back; then a short settle
    task automatic drain();
        wait (pending_words.size() == 0 && due_responses.size() == 0);
        repeat (8) @(posedge clk);
    endtask

    // random mix around the configured region: mostly slot-aligned
    // frees/reserves/allocs, some misaligned ones and raw noise
    task automatic random_burst(int count);
        bit [63:0] u, slots, o;
        int        p;
        u = (sh_slab == 0) ? 64'd1 : sh_slab;
        slots = sh_rsize / u;
        if (slots > 40)
            slots = 40;
        for (int k = 0; k < count; k++)
        begin
            p = $urandom_range(99);
            o = sh_rstart + u * 64'($urandom_range(0, int'(slots) + 2));
            if ($urandom_range(9) == 0)
                o = o + 64'($urandom_range(1, 3)) - 64'd2;
            if (p < 35)
                push(sfsa_pkg::ACT_ALLOC, {$urandom, $urandom});
            else if (p < 65)
                push(sfsa_pkg::ACT_FREE, o);
            else if (p < 88)
                push(sfsa_pkg::ACT_RESERVE, o);
            else if (p < 95)
                push(2'($urandom_range(1, 2)), {$urandom, $urandom} & MASK48);
            else
                push(ACT_BAD, {$urandom, $urandom});
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: four slabs from 0x1000, walk through each case
        setup(49'h1000, 49'h4000, 49'd4096);
        for (int k = 0; k < 5; k++)
            push(sfsa_pkg::ACT_ALLOC, 64'd0);             // last one: no space
        push(sfsa_pkg::ACT_FREE, 64'h2000);                // isolated insert
        push(sfsa_pkg::ACT_FREE, 64'h4000);                // insert after
        push(sfsa_pkg::ACT_FREE, 64'h3000);                // merge both sides
        push(sfsa_pkg::ACT_FREE, 64'h1000);                // merge into next
        push(sfsa_pkg::ACT_FREE, 64'h3800);                // overlap
        push(sfsa_pkg::ACT_FREE, 64'h9000);                // outside region, accepted
        push(sfsa_pkg::ACT_FREE, 64'h8000);                // merges into next
        push(sfsa_pkg::ACT_RESERVE, 64'h2000);             // split
        push(sfsa_pkg::ACT_RESERVE, 64'h1000);             // whole segment
        push(sfsa_pkg::ACT_RESERVE, 64'h4000);             // tail
        push(sfsa_pkg::ACT_RESERVE, 64'h3000);             // whole segment
        push(sfsa_pkg::ACT_RESERVE, 64'h3000);             // not free
        push(sfsa_pkg::ACT_FREE, MASK48);                  // runs past 2^48
        push(sfsa_pkg::ACT_FREE, 64'hFFFF_FFFF_F000);      // last slab of the space
        push(ACT_BAD, MASK48);                             // unknown action
        push(sfsa_pkg::ACT_ALLOC, 64'd0);
        drain();

        // extremes: whole space with 4 GiB slabs; clipped region; empty
        setup(49'h0, 49'h1_0000_0000_0000, 49'h1_0000_0000);
        push(sfsa_pkg::ACT_ALLOC, 64'd0);
        push(sfsa_pkg::ACT_RESERVE, 64'hFFFF_0000_0000);
        push(sfsa_pkg::ACT_FREE, 64'd0);
        drain();
        setup(49'hFFFF_FFFF_0000, 49'h1_FFFF_FFFF_FFFF, 49'h0);  // slab 0 acts as 1
        random_burst(20);
        drain();
        setup(49'h1_5000, 49'hFFF, 49'd4096);                    // smaller than a slab
        random_burst(10);
        drain();

        // fragment a byte-slab region until the table fills
        src_idle = 67;
        snk_idle = 37;
        setup(49'h0, 49'd300, 49'd1);
        for (int k = 0; k < 66; k++)
            push(sfsa_pkg::ACT_RESERVE, 64'(2 * k + 1));
        push(sfsa_pkg::ACT_RESERVE, 64'd250);              // split with a full table
        push(sfsa_pkg::ACT_FREE, 64'd1000);                // insert with a full table
        for (int k = 0; k < 40; k++)
            push(sfsa_pkg::ACT_FREE, 64'(2 * $urandom_range(0, 70) + 1));
        drain();

        // random phases over a spread of settings
        for (int ph = 0; ph < 12; ph++)
        begin
            if (ph == 4)
            begin
                src_idle = 0;
                snk_idle = 0;
            end
            case ($urandom_range(3))
                0: setup(49'({1'b0, $urandom_range(0, 255), 12'h0}),
                         49'd4096 * 49'($urandom_range(1, 24)), 49'd4096);
                1: setup(49'({$urandom, $urandom} & MASK48), 49'($urandom_range(0, 60)),
                         49'($urandom_range(1, 4)));
                2: setup({1'b0, 16'hFFFF, $urandom}, 49'({$urandom, $urandom}),
                         49'({$urandom, $urandom}));
                default: setup(49'($urandom_range(0, 1000)), 49'($urandom_range(8, 200)),
                               49'($urandom_range(1, 8)));
            endcase
            random_burst(55);
            drain();
        end

        $display("covered %0d request words, %0d responses, %0d register writes",
                 words_in, words_out, cfg_writes);
        $display("status counts ok/nospace/notfree/full/overlap: %0d %0d %0d %0d %0d",
                 sts_seen[0], sts_seen[1], sts_seen[2], sts_seen[3], sts_seen[4]);
        if (errors == 0)
            $display("slab_free_segment_allocator_top_test: PASS");
        else
            $display("slab_free_segment_allocator_top_test: FAIL");
        $finish;
    end

endmodule
